FILE: hw/rtl/spatial_access_generation_tracker_macros.svh
// Assertion helpers for the generation tracker.
`ifndef SPATIAL_ACCESS_GENERATION_TRACKER_MACROS_SVH
`define SPATIAL_ACCESS_GENERATION_TRACKER_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define SAGT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication.
`define SAGT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

FILE: hw/rtl/sagt_pkg.sv
// -----------------------------------------------------------------------------
// sagt_pkg
// Shared sizes, payload types and control structs of the generation tracker.
// -----------------------------------------------------------------------------
package sagt_pkg;
	localparam int RegionBlocks = 32;
	localparam int AccEntries = 32;
	localparam int FilterEntries = 32;
	localparam int OffW = $clog2(RegionBlocks);
	localparam int TagW = 58 - OffW;
	localparam int AccIdxW = (AccEntries > 1) ? $clog2(AccEntries) : 1;
	localparam int FltIdxW = (FilterEntries > 1) ? $clog2(FilterEntries) : 1;

	typedef enum logic {
		FUNC_RECORD = 1'b0,
		FUNC_EVICT  = 1'b1
	} func_t;

	typedef struct packed {
		logic        func;
		logic [57:0] block_addr;
		logic [47:0] access_pc;
		logic        store_op;
		logic [31:0] stamp;
	} req_t;

	typedef struct packed {
		logic        gen_valid;
		logic [52:0] gen_region_tag;
		logic [47:0] gen_trigger_pc;
		logic [4:0]  gen_trigger_offset;
		logic [31:0] gen_access_mask;
		logic [31:0] gen_read_mask;
	} rsp_t;

	// controller -> datapath
	typedef struct packed {
		logic load;   // capture request and search tables
		logic commit; // apply update and produce result
	} cmd_t;
endpackage

FILE: hw/rtl/sagt_if.sv
// -----------------------------------------------------------------------------
// sagt_if
// Valid/ready channels carrying one request or one result.
// -----------------------------------------------------------------------------
interface sagt_req_if ();
	logic           valid;
	logic           ready;
	sagt_pkg::req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface sagt_rsp_if ();
	logic           valid;
	logic           ready;
	sagt_pkg::rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/sagt_datapath.sv
// -----------------------------------------------------------------------------
// sagt_datapath
// Filter and accumulation tables, tag match, slot choice and update.
// -----------------------------------------------------------------------------
module sagt_datapath (
	input  logic           clk,
	input  logic           arst_n,
	input  sagt_pkg::cmd_t cmd,
	input  sagt_pkg::req_t req,
	output sagt_pkg::rsp_t rsp
);
	import sagt_pkg::*;

	logic [AccEntries-1:0]    acc_v_q;
	logic [TagW-1:0]          acc_tag_q [AccEntries];
	logic [47:0]              acc_pc_q [AccEntries];
	logic [OffW-1:0]          acc_off_q [AccEntries];
	logic [RegionBlocks-1:0]  acc_am_q [AccEntries];
	logic [RegionBlocks-1:0]  acc_rm_q [AccEntries];
	logic [31:0]              acc_st_q [AccEntries];
	logic [FilterEntries-1:0] flt_v_q;
	logic [TagW-1:0]          flt_tag_q [FilterEntries];
	logic [47:0]              flt_pc_q [FilterEntries];
	logic [OffW-1:0]          flt_off_q [FilterEntries];
	logic [FilterEntries-1:0] flt_rd_q;
	logic [31:0]              flt_st_q [FilterEntries];

	req_t                req_s1;
	logic                acc_hit_s1, flt_hit_s1, acc_full_s1;
	logic [AccIdxW-1:0]  acc_idx_s1, acc_slot_s1;
	logic [FltIdxW-1:0]  flt_idx_s1, flt_slot_s1;

	logic [TagW-1:0]     tag, tag_s1;
	logic [OffW-1:0]     off_s1;
	logic                acc_hit, flt_hit, acc_full, flt_full;
	logic [AccIdxW-1:0]  acc_idx, acc_slot, acc_lru;
	logic [FltIdxW-1:0]  flt_idx, flt_slot, flt_lru;
	rsp_t                rsp_d;

	assign tag = req.block_addr[57:OffW];

	// stage 1 search: lowest match, lowest free, oldest stamp
	// oldest stamp by a pairwise tree; entry counts are powers of two
	always_comb begin
		logic [31:0]        mst [1:2*AccEntries-1];
		logic [AccIdxW-1:0] mix [1:2*AccEntries-1];
		acc_hit = 1'b0; acc_idx = '0; acc_full = 1'b1; acc_slot = '0;
		for (int i = AccEntries - 1; i >= 0; i--) begin
			if (acc_v_q[i] && acc_tag_q[i] == tag) begin
				acc_hit = 1'b1; acc_idx = AccIdxW'(i);
			end
			if (!acc_v_q[i]) begin
				acc_full = 1'b0; acc_slot = AccIdxW'(i);
			end
		end
		for (int i = 0; i < AccEntries; i++) begin
			mst[AccEntries+i] = acc_st_q[i];
			mix[AccEntries+i] = AccIdxW'(i);
		end
		// left child wins ties, so the lowest index is kept
		for (int n = AccEntries - 1; n >= 1; n--) begin
			if (mst[2*n+1] < mst[2*n]) begin
				mst[n] = mst[2*n+1]; mix[n] = mix[2*n+1];
			end else begin
				mst[n] = mst[2*n]; mix[n] = mix[2*n];
			end
		end
		acc_lru = mix[1];
		if (acc_full) acc_slot = acc_lru;
	end

	always_comb begin
		logic [31:0]        mst [1:2*FilterEntries-1];
		logic [FltIdxW-1:0] mix [1:2*FilterEntries-1];
		flt_hit = 1'b0; flt_idx = '0; flt_full = 1'b1; flt_slot = '0;
		for (int i = FilterEntries - 1; i >= 0; i--) begin
			if (flt_v_q[i] && flt_tag_q[i] == tag) begin
				flt_hit = 1'b1; flt_idx = FltIdxW'(i);
			end
			if (!flt_v_q[i]) begin
				flt_full = 1'b0; flt_slot = FltIdxW'(i);
			end
		end
		for (int i = 0; i < FilterEntries; i++) begin
			mst[FilterEntries+i] = flt_st_q[i];
			mix[FilterEntries+i] = FltIdxW'(i);
		end
		for (int n = FilterEntries - 1; n >= 1; n--) begin
			if (mst[2*n+1] < mst[2*n]) begin
				mst[n] = mst[2*n+1]; mix[n] = mix[2*n+1];
			end else begin
				mst[n] = mst[2*n]; mix[n] = mix[2*n];
			end
		end
		flt_lru = mix[1];
		if (flt_full) flt_slot = flt_lru;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_s1 <= req;
			acc_hit_s1 <= acc_hit; acc_idx_s1 <= acc_idx;
			acc_full_s1 <= acc_full; acc_slot_s1 <= acc_slot;
			flt_hit_s1 <= flt_hit; flt_idx_s1 <= flt_idx; flt_slot_s1 <= flt_slot;
		end
	end

	assign tag_s1 = req_s1.block_addr[57:OffW];
	assign off_s1 = req_s1.block_addr[OffW-1:0];

	logic                    rd;
	logic [RegionBlocks-1:0] bit_s1, tbit;
	assign rd = !req_s1.store_op;
	assign bit_s1 = RegionBlocks'(1) << off_s1;
	assign tbit = RegionBlocks'(1) << flt_off_q[flt_idx_s1];

	function automatic rsp_t acc_out(
		input logic [TagW-1:0] t, input logic [47:0] p, input logic [OffW-1:0] o,
		input logic [RegionBlocks-1:0] am, input logic [RegionBlocks-1:0] rm);
		rsp_t r;
		r = '0;
		r.gen_valid = 1'b1;
		r.gen_region_tag = 53'(t);
		r.gen_trigger_pc = p;
		r.gen_trigger_offset = 5'(o);
		r.gen_access_mask = 32'(am);
		r.gen_read_mask = 32'(rm);
		return r;
	endfunction

	always_comb begin
		rsp_d = '0;
		if (req_s1.func == FUNC_EVICT) begin
			if (acc_hit_s1)
				rsp_d = acc_out(acc_tag_q[acc_idx_s1], acc_pc_q[acc_idx_s1],
					acc_off_q[acc_idx_s1], acc_am_q[acc_idx_s1], acc_rm_q[acc_idx_s1]);
		end else if (!acc_hit_s1 && flt_hit_s1 && flt_off_q[flt_idx_s1] != off_s1
				&& acc_full_s1) begin
			// full table: the replaced entry ends its generation
			rsp_d = acc_out(acc_tag_q[acc_slot_s1], acc_pc_q[acc_slot_s1],
				acc_off_q[acc_slot_s1], acc_am_q[acc_slot_s1], acc_rm_q[acc_slot_s1]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_v_q <= '0;
			flt_v_q <= '0;
		end else if (cmd.commit) begin
			rsp <= rsp_d;
			if (req_s1.func == FUNC_EVICT) begin
				if (flt_hit_s1) flt_v_q[flt_idx_s1] <= 1'b0;
				if (acc_hit_s1) acc_v_q[acc_idx_s1] <= 1'b0;
			end else if (acc_hit_s1) begin
				acc_st_q[acc_idx_s1] <= req_s1.stamp;
				if ((acc_am_q[acc_idx_s1] & bit_s1) == '0) begin
					acc_am_q[acc_idx_s1] <= acc_am_q[acc_idx_s1] | bit_s1;
					acc_rm_q[acc_idx_s1] <= rd ? (acc_rm_q[acc_idx_s1] | bit_s1)
						: (acc_rm_q[acc_idx_s1] & ~bit_s1);
				end
			end else if (flt_hit_s1) begin
				if (flt_off_q[flt_idx_s1] == off_s1) begin
					flt_pc_q[flt_idx_s1] <= req_s1.access_pc;
					flt_st_q[flt_idx_s1] <= req_s1.stamp;
					flt_rd_q[flt_idx_s1] <= rd;
				end else begin
					// promote to accumulation
					acc_v_q[acc_slot_s1] <= 1'b1;
					acc_tag_q[acc_slot_s1] <= flt_tag_q[flt_idx_s1];
					acc_pc_q[acc_slot_s1] <= flt_pc_q[flt_idx_s1];
					acc_off_q[acc_slot_s1] <= flt_off_q[flt_idx_s1];
					acc_am_q[acc_slot_s1] <= tbit | bit_s1;
					acc_rm_q[acc_slot_s1] <= ((flt_rd_q[flt_idx_s1] ? tbit : '0) & ~bit_s1)
						| (rd ? bit_s1 : '0);
					acc_st_q[acc_slot_s1] <= req_s1.stamp;
					flt_v_q[flt_idx_s1] <= 1'b0;
				end
			end else begin
				flt_v_q[flt_slot_s1] <= 1'b1;
				flt_tag_q[flt_slot_s1] <= tag_s1;
				flt_pc_q[flt_slot_s1] <= req_s1.access_pc;
				flt_off_q[flt_slot_s1] <= off_s1;
				flt_rd_q[flt_slot_s1] <= rd;
				flt_st_q[flt_slot_s1] <= req_s1.stamp;
			end
		end
	end
endmodule

FILE: hw/rtl/sagt_ctrl.sv
// -----------------------------------------------------------------------------
// sagt_ctrl
// Sequencer: search, update, then hold the result until taken.
// -----------------------------------------------------------------------------
`include "spatial_access_generation_tracker_macros.svh"
module sagt_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	output sagt_pkg::cmd_t cmd
);
	import sagt_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_UPD  = 3'b010,
		ST_OUT  = 3'b100
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign cmd.load = in_valid && in_ready;
	assign cmd.commit = (state_q == ST_UPD);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_UPD;
			ST_UPD:  state_d = ST_OUT;
			ST_OUT:  if (out_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	`SAGT_ASSERT_NXT(a_load_commit, clk, arst_n, cmd.load, cmd.commit, "commit must follow load")
	`SAGT_ASSERT_NXT(a_commit_out, clk, arst_n, cmd.commit, out_valid, "result must follow commit")
	`SAGT_ASSERT_IMP(a_no_overlap, clk, arst_n, out_valid, !in_ready, "request taken while result held")
endmodule

FILE: hw/rtl/spatial_access_generation_tracker.sv
// -----------------------------------------------------------------------------
// spatial_access_generation_tracker
// Active generation table: filter and accumulation tables of a spatial
// prefetcher.
//
// Channel | Dir | Payload
// req     | in  | func, block_addr, access_pc, store_op, stamp
// rsp     | out | gen_valid, gen_region_tag, gen_trigger_pc, gen_trigger_offset,
//         |     | gen_access_mask, gen_read_mask
//
// Each request goes through a search of both tables, an update of them,
// and the hand-over of the result, which is held while the output stalls.
// Reset clears all valid bits at once; no clearing pass.
// A stalled result holds the block; no new request is taken meanwhile.
// -----------------------------------------------------------------------------
module spatial_access_generation_tracker (
	input logic clk,
	input logic arst_n,
	sagt_req_if.sink   req,
	sagt_rsp_if.source rsp
);
	import sagt_pkg::*;

	cmd_t cmd;

	sagt_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(req.valid), .in_ready(req.ready),
		.out_valid(rsp.valid), .out_ready(rsp.ready),
		.cmd(cmd)
	);

	sagt_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .req(req.data), .rsp(rsp.data)
	);
endmodule
